### design/event_fifo_with_cancel_defines.svh
// Assertion macros for the event queue with cancel.
// Used by the top level; expects signals named clk and rst_n in scope.
`ifndef EVENT_FIFO_WITH_CANCEL_DEFINES_SVH
`define EVENT_FIFO_WITH_CANCEL_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define EFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define EFC_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define EFC_ASSERT(lbl, prop, msg)
`define EFC_NEVER(lbl, expr, msg)
`endif
`endif

### design/efc_pkg.sv
// Shared types and constants for the event queue with cancel.
// No dependencies; imported by every module of the block.
`default_nettype none
package efc_pkg;

    localparam int DEPTH     = 16;
    localparam int TAG_BITS  = 32;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 5;
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int EV_TAG_W  = 32;
    localparam int PEND_W    = 5;
    localparam int ADDR_W    = 3;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 40;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_PROCESS = 2'd1,
        CMD_CANCEL  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_DONE     = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_NOTFOUND = 2'd3
    } status_t;

    // Per-cycle control broadcast to every cell of the row.
    typedef struct packed {
        logic pop;     // every cell takes its younger neighbor's tag
        logic cancel;  // cells at or behind the first match shift forward
        logic load;    // the tail cell stores the key
    } cell_ctrl_t;

endpackage
`default_nettype wire

### design/efc_cell.sv
// One storage cell of the queue row: holds a tag, compares it to the key.
// Depends on efc_pkg.
`default_nettype none
module efc_cell
    import efc_pkg::*;
(
    input  wire logic                clk,
    input  wire cell_ctrl_t          ctrl,
    input  wire logic [TAG_BITS-1:0] key,
    input  wire logic                occ,
    input  wire logic                is_tail,
    input  wire logic [TAG_BITS-1:0] nbr_tag,
    input  wire logic                hit_in,
    output logic                     hit_out,
    output logic [TAG_BITS-1:0]      tag_out
);

    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] tag_next;
    logic                match;

    assign match   = occ && (tag_reg == key);
    assign hit_out = hit_in || match;
    assign tag_out = tag_reg;

    // A cancel shifts this cell only when it or an older cell matched.
    always_comb
    begin
        tag_next = tag_reg;
        if (ctrl.pop || (ctrl.cancel && hit_out))
        begin
            tag_next = nbr_tag;
        end
        else if (ctrl.load && is_tail)
        begin
            tag_next = key;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

endmodule
`default_nettype wire

### design/event_fifo_with_cancel.sv
// Event queue with cancel: a row of DEPTH cells with an APB register port.
// Depends on efc_pkg, efc_cell and event_fifo_with_cancel_defines.svh.
//
// Usage: each input item on the s_ channel carries a command in s_tuser and a
// tag in s_tdata. Add places the tag at the tail, process removes the head,
// and cancel removes the oldest entry holding the tag while the younger
// entries move one cell toward the head, so the order is kept. Each item gives
// exactly one result item on the m_ channel: status in m_tuser, the tag and
// the pending count in m_tdata.
// The result item is valid in the cycle after acceptance, and the block
// takes one item per cycle while the receiver is not stalling. This rate
// is set by the cell row: every cell compares its tag with the key in
// parallel and a single shift step closes any gap.
// The result sits in an output register; s_tready stays high while that
// register is empty or being taken, so a stalled receiver holds the result
// and stalls the sender with it, and nothing is lost or repeated.
// Reset empties the queue and sets the capacity register to 16. The tag
// cells themselves are not cleared; only cells below the count are read. The
// capacity register (address 0) must be written only while idle; not enforced here.
`default_nettype none
`include "event_fifo_with_cancel_defines.svh"
module event_fifo_with_cancel
    import efc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input item channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] event_tag
    input  wire logic [1:0]            s_tuser,   // [1:0] command
    // result item channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [31:0] result_tag,
                                                  // [36:32] pending_count, rest zero
    output logic [1:0]                 m_tuser,   // [1:0] status
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // ---------------------------------------------------------------
    // Configuration register. Only bit 2 of the address selects the
    // register; anything above the first register is ignored.
    // ---------------------------------------------------------------
    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == 1'b0) ? {{(32-CAP_W){1'b0}}, cap_reg} : 32'd0;

    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_wr && (paddr[2] == 1'b0))
        begin
            cap_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    // ---------------------------------------------------------------
    // Input decode and queue status.
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                in_acc;
    logic                empty;
    logic                full;
    logic                found;
    cmd_t                cmd;
    logic [TAG_BITS-1:0] key;
    cell_ctrl_t          ctrl;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    status_t                out_status_reg;
    status_t                out_status_next;
    logic [EV_TAG_W-1:0]    out_tag_reg;
    logic [EV_TAG_W-1:0]    out_tag_next;
    logic [PEND_W-1:0]      out_cnt_reg;
    logic [PEND_W-1:0]      out_cnt_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign key      = TAG_BITS'(s_tdata[EV_TAG_W-1:0]);
    assign empty    = (count_reg == '0);
    // A capacity above the built depth is covered by the depth check.
    assign full     = (CMP_W'(count_reg) >= CMP_W'(cap_reg))
                   || (count_reg == CNT_W'(DEPTH));

    // ---------------------------------------------------------------
    // Cell row. Cell 0 holds the oldest entry; each cell hands its tag
    // to the older neighbor and passes the match flag to the younger one.
    // ---------------------------------------------------------------
    logic [TAG_BITS-1:0] cell_tag [DEPTH];
    logic [DEPTH:0]      hit_chain;

    assign hit_chain[0] = 1'b0;
    assign found        = hit_chain[DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [TAG_BITS-1:0] nbr;
            if (gi == DEPTH - 1)
            begin : g_last
                assign nbr = cell_tag[gi];
            end
            else
            begin : g_mid
                assign nbr = cell_tag[gi+1];
            end

            efc_cell u_cell (
                .clk     (clk),
                .ctrl    (ctrl),
                .key     (key),
                .occ     (CNT_W'(gi) < count_reg),
                .is_tail (CNT_W'(gi) == count_reg),
                .nbr_tag (nbr),
                .hit_in  (hit_chain[gi]),
                .hit_out (hit_chain[gi+1]),
                .tag_out (cell_tag[gi])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // Operation: cell control, new count and the result item.
    // A cancel that hits returns the key itself, since the entry equals it.
    // ---------------------------------------------------------------
    always_comb
    begin
        ctrl            = '0;
        count_next      = count_reg;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        if (in_acc)
        begin
            out_valid_next  = 1'b1;
            out_status_next = STATUS_DONE;
            out_tag_next    = '0;
            case (cmd)
                CMD_ADD:
                begin
                    if (full)
                    begin
                        out_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        ctrl.load    = 1'b1;
                        count_next   = count_reg + 1'b1;
                        out_tag_next = EV_TAG_W'(key);
                    end
                end
                CMD_PROCESS:
                begin
                    if (empty)
                    begin
                        out_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        ctrl.pop     = 1'b1;
                        count_next   = count_reg - 1'b1;
                        out_tag_next = EV_TAG_W'(cell_tag[0]);
                    end
                end
                CMD_CANCEL:
                begin
                    if (empty)
                    begin
                        out_status_next = STATUS_EMPTY;
                    end
                    else if (!found)
                    begin
                        out_status_next = STATUS_NOTFOUND;
                    end
                    else
                    begin
                        ctrl.cancel  = 1'b1;
                        count_next   = count_reg - 1'b1;
                        out_tag_next = EV_TAG_W'(key);
                    end
                end
                default:
                begin
                    // Unused command: queue untouched, reported as done.
                    out_status_next = STATUS_DONE;
                end
            endcase
            out_cnt_next = PEND_W'(count_next);
        end
        else
        begin
            out_cnt_next = out_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_tag_reg    <= out_tag_next;
        out_cnt_reg    <= out_cnt_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(OUT_DATA_W-EV_TAG_W-PEND_W){1'b0}}, out_cnt_reg, out_tag_reg};

    // ---------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------
    `EFC_NEVER(a_count_bound, count_reg > CNT_W'(DEPTH), "count above depth")
    `EFC_ASSERT(a_add_grows, (in_acc && cmd == CMD_ADD && !full) |=> (count_reg == $past(count_reg) + 1'b1), "add did not grow count")
    `EFC_ASSERT(a_pop_empty, (in_acc && cmd == CMD_PROCESS && empty) |=> (m_tvalid && m_tuser == STATUS_EMPTY), "process on empty not reported")
    `EFC_ASSERT(a_cancel_hit, (in_acc && cmd == CMD_CANCEL && !empty && found) |=> (m_tuser == STATUS_DONE && count_reg == $past(count_reg) - 1'b1), "cancel hit not applied")

endmodule
`default_nettype wire
